// ----- src/rgb565_to_hsv888_convert_macros.svh -----
`ifndef RGB565_TO_HSV888_CONVERT_MACROS_SVH
`define RGB565_TO_HSV888_CONVERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define R2H_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("r2h check failed");

// next-cycle implication, disabled while reset is high
`define R2H_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("r2h check failed");

`endif

// ----- src/r2h_pkg.sv -----
`default_nettype none

package r2h_pkg;

   localparam int unsigned NUM_DIV_STAGES = 4;
   // unpack, span, divider stages, finish
   localparam int unsigned NUM_STAGES = NUM_DIV_STAGES + 3;

   localparam logic [7:0] HUE_BASE_RED   = 8'd0;
   localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
   localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;
   localparam logic [7:0] HUE_STEP       = 8'd43;
   localparam logic [7:0] CHAN5_MAX      = 8'd31;
   localparam logic [5:0] CHAN6_MAX      = 6'd63;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [7:0]  val;
      logic [7:0]  base;
      logic        neg;
      logic        hue_zero;
      logic        sat_zero;
      logic [7:0]  span;
      logic [15:0] sat_rem;
      logic [15:0] hue_rem;
      logic [7:0]  sat_q;
      logic [7:0]  hue_q;
   } div_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
   } hsv_type;

   // c*255/31 = 8c + floor(7c/31)
   function automatic logic [7:0] scale5(logic [4:0] c);
      logic [7:0] c7;
      logic [2:0] k;
      c7 = {c, 3'b000} - {3'b000, c};
      k = 3'd0;
      for (int i = 1; i <= 7; i++) begin
         if (c7 >= 8'(CHAN5_MAX * 8'(i))) k = k + 3'd1;
      end
      return {c, 3'b000} + {5'b00000, k};
   endfunction

   // c*255/63 = 4c + floor(c/21)
   function automatic logic [7:0] scale6(logic [5:0] c);
      logic [1:0] k;
      k = 2'd0;
      if (c >= 6'd21) k = k + 2'd1;
      if (c >= 6'd42) k = k + 2'd1;
      if (c >= CHAN6_MAX) k = k + 2'd1;
      return {c, 2'b00} + {6'b000000, k};
   endfunction

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [16:0] div_step(logic [15:0] rem, logic [7:0] d,
                                            int unsigned sh);
      logic [15:0] dd;
      dd = 16'({8'b00000000, d} << sh);
      if (rem >= dd) return {1'b1, rem - dd};
      else return {1'b0, rem};
   endfunction

endpackage

`default_nettype wire

// ----- src/r2h_ifs.sv -----
`default_nettype none

interface r2h_pix_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

interface r2h_hsv_if;
   logic       valid;
   logic       ready;
   logic [7:0] hue_out;
   logic [7:0] sat_out;
   logic [7:0] val_out;

   modport source (output valid, output hue_out, output sat_out, output val_out,
                   input ready);
   modport sink (input valid, input hue_out, input sat_out, input val_out,
                 output ready);
endinterface

`default_nettype wire

// ----- src/r2h_unpack.sv -----
`default_nettype none

module r2h_unpack (
   input  logic             clock,
   input  logic             enable,
   input  logic [15:0]      pixel,
   output r2h_pkg::rgb_type rgb
);
   import r2h_pkg::*;

   rgb_type rgb_ff, rgb_in;

   always_comb begin
      rgb_in.red   = scale5(pixel[15:11]);
      rgb_in.green = scale6(pixel[10:5]);
      rgb_in.blue  = scale5(pixel[4:0]);
   end

   always_ff @(posedge clock) begin
      if (enable) rgb_ff <= rgb_in;
   end

   assign rgb = rgb_ff;
endmodule

`default_nettype wire

// ----- src/r2h_span.sv -----
`default_nettype none

module r2h_span (
   input  logic             clock,
   input  logic             enable,
   input  r2h_pkg::rgb_type rgb,
   output r2h_pkg::div_type dv
);
   import r2h_pkg::*;

   div_type    dv_ff, dv_in;
   logic [7:0] mx, mn, span, op_a, op_b, absd, base;

   always_comb begin
      mx = (rgb.red >= rgb.green) ? rgb.red : rgb.green;
      mx = (mx >= rgb.blue) ? mx : rgb.blue;
      mn = (rgb.red <= rgb.green) ? rgb.red : rgb.green;
      mn = (mn <= rgb.blue) ? mn : rgb.blue;
      span = mx - mn;

      // ties: red wins over green, green over blue
      if (mx == rgb.red) begin
         op_a = rgb.green;
         op_b = rgb.blue;
         base = HUE_BASE_RED;
      end else if (mx == rgb.green) begin
         op_a = rgb.blue;
         op_b = rgb.red;
         base = HUE_BASE_GREEN;
      end else begin
         op_a = rgb.red;
         op_b = rgb.green;
         base = HUE_BASE_BLUE;
      end
      absd = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

      dv_in.val      = mx;
      dv_in.base     = base;
      dv_in.neg      = op_a < op_b;
      dv_in.hue_zero = span == 8'd0;
      dv_in.sat_zero = mx == 8'd0;
      dv_in.span     = span;
      dv_in.sat_rem  = {span, 8'b00000000} - {8'b00000000, span};
      dv_in.hue_rem  = 16'(absd) * 16'(HUE_STEP);
      dv_in.sat_q    = 8'd0;
      dv_in.hue_q    = 8'd0;
   end

   always_ff @(posedge clock) begin
      if (enable) dv_ff <= dv_in;
   end

   assign dv = dv_ff;
endmodule

`default_nettype wire

// ----- src/r2h_div_stage.sv -----
`default_nettype none

// two quotient bits per stage for both dividers: HI_BIT and HI_BIT-1
module r2h_div_stage #(
   parameter int unsigned HI_BIT = 7
) (
   input  logic             clock,
   input  logic             enable,
   input  r2h_pkg::div_type d_in,
   output r2h_pkg::div_type d_out
);
   import r2h_pkg::*;

   div_type     dv_ff, dv_in;
   logic [16:0] sat_hi, sat_lo, hue_hi, hue_lo;

   always_comb begin
      dv_in  = d_in;
      sat_hi = div_step(d_in.sat_rem, d_in.val, HI_BIT);
      sat_lo = div_step(sat_hi[15:0], d_in.val, HI_BIT - 1);
      hue_hi = div_step(d_in.hue_rem, d_in.span, HI_BIT);
      hue_lo = div_step(hue_hi[15:0], d_in.span, HI_BIT - 1);
      dv_in.sat_rem           = sat_lo[15:0];
      dv_in.hue_rem           = hue_lo[15:0];
      dv_in.sat_q[HI_BIT]     = sat_hi[16];
      dv_in.sat_q[HI_BIT - 1] = sat_lo[16];
      dv_in.hue_q[HI_BIT]     = hue_hi[16];
      dv_in.hue_q[HI_BIT - 1] = hue_lo[16];
   end

   always_ff @(posedge clock) begin
      if (enable) dv_ff <= dv_in;
   end

   assign d_out = dv_ff;
endmodule

`default_nettype wire

// ----- src/r2h_finish.sv -----
`default_nettype none

module r2h_finish (
   input  logic             clock,
   input  logic             enable,
   input  r2h_pkg::div_type dv,
   output r2h_pkg::hsv_type hsv
);
   import r2h_pkg::*;

   hsv_type hsv_ff, hsv_in;

   always_comb begin
      // quotient truncates toward zero, sum wraps mod 256
      if (dv.hue_zero) hsv_in.hue = 8'd0;
      else if (dv.neg) hsv_in.hue = dv.base - dv.hue_q;
      else hsv_in.hue = dv.base + dv.hue_q;
      // divisor is zero for black, quotient is junk there
      hsv_in.sat = dv.sat_zero ? 8'd0 : dv.sat_q;
      hsv_in.val = dv.val;
   end

   always_ff @(posedge clock) begin
      if (enable) hsv_ff <= hsv_in;
   end

   assign hsv = hsv_ff;
endmodule

`default_nettype wire

// ----- src/rgb565_to_hsv888_convert.sv -----
// RGB565 to HSV888 pixel converter.
// req_if carries one RGB565 pixel per item (valid/ready); rsp_if returns
// the hue, saturation and value triple for it, one result item per pixel,
// in order.
// Seven register stages: unpack/scale, max/min/span, four divider stages
// that each resolve two quotient bits of the saturation and hue divisions,
// and an output stage; each pixel passes through them in that order.
// Throughput is one pixel per cycle while the receiver is not stalling.
// Every stage has its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles close up under a stall and req_if.ready
// stays high while any stage is free.
// When rsp_if.ready is low the result item holds on rsp_if and items back
// up stage by stage; nothing is dropped or repeated.
// reset (synchronous, active high) clears all valid bits; the pipeline
// starts empty and takes an item in the first cycle after reset.
`default_nettype none

module rgb565_to_hsv888_convert (
   input logic        clock,
   input logic        reset,
   r2h_pix_if.sink    req_if,
   r2h_hsv_if.source  rsp_if
);
   import r2h_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, stage_ready;

   rgb_type rgb;
   div_type div_chain [0:NUM_DIV_STAGES];
   hsv_type hsv;

   always_comb begin
      stage_ready[NUM_STAGES-1] = rsp_if.ready || !valid_ff[NUM_STAGES-1];
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = stage_ready[i+1] || !valid_ff[i];
      end
      valid_in[0] = stage_ready[0] ? req_if.valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = stage_ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   r2h_unpack u_unpack (
      .clock  (clock),
      .enable (stage_ready[0]),
      .pixel  (req_if.pixel_in),
      .rgb    (rgb)
   );

   r2h_span u_span (
      .clock  (clock),
      .enable (stage_ready[1]),
      .rgb    (rgb),
      .dv     (div_chain[0])
   );

   for (genvar j = 0; j < NUM_DIV_STAGES; j++) begin : g_div
      r2h_div_stage #(
         .HI_BIT (2 * (NUM_DIV_STAGES - j) - 1)
      ) u_div (
         .clock  (clock),
         .enable (stage_ready[j+2]),
         .d_in   (div_chain[j]),
         .d_out  (div_chain[j+1])
      );
   end

   r2h_finish u_finish (
      .clock  (clock),
      .enable (stage_ready[NUM_STAGES-1]),
      .dv     (div_chain[NUM_DIV_STAGES]),
      .hsv    (hsv)
   );

   assign req_if.ready   = stage_ready[0];
   assign rsp_if.valid   = valid_ff[NUM_STAGES-1];
   assign rsp_if.hue_out = hsv.hue;
   assign rsp_if.sat_out = hsv.sat;
   assign rsp_if.val_out = hsv.val;
endmodule

`default_nettype wire

// ----- src/r2h_checker.sv -----
`default_nettype none
`include "rgb565_to_hsv888_convert_macros.svh"

module r2h_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] hue_out,
   input logic [7:0] sat_out,
   input logic [7:0] val_out
);
   // a stalled result item stays offered
   `R2H_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled result item keeps its fields
   `R2H_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable({hue_out, sat_out, val_out}))

   // black gives no saturation
   `R2H_ASSERT_NOW(a_black_sat, clock, reset, rsp_valid && val_out == 8'd0, sat_out == 8'd0)

   // zero saturation only for grey or black, which carry hue zero
   `R2H_ASSERT_NOW(a_grey_hue, clock, reset, rsp_valid && sat_out == 8'd0, hue_out == 8'd0)

   // pipeline comes out of reset empty
   `R2H_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)
endmodule

bind rgb565_to_hsv888_convert r2h_checker u_r2h_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .hue_out   (rsp_if.hue_out),
   .sat_out   (rsp_if.sat_out),
   .val_out   (rsp_if.val_out)
);

`default_nettype wire
